// ===== sv/ssr_pkg.sv =====
// Package for the streaming substring replacer: sizes, payload types, states, helpers.
package ssr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;

  localparam int LEN_W      = 4;
  localparam int WORD_W     = 64;
  localparam int WORD_BYTES = WORD_W / 8;
  localparam int CNT_W      = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int RIDX_W     = $clog2(REPLACE_MAX + 1);
  localparam int CFG_IDX_W  = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP     = 2'd3;

  // Reset contents: pattern "Cao", replacement "Ling"
  localparam logic [LEN_W-1:0]  PAT_LEN_RST = 4'd3;
  localparam logic [WORD_W-1:0] PAT_RST     = 64'h0000_0000_006F_6143;
  localparam logic [LEN_W-1:0]  REP_LEN_RST = 4'd4;
  localparam logic [WORD_W-1:0] REP_RST     = 64'h0000_0000_676E_694C;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } out_item_t;

  typedef logic [PATTERN_MAX-1:0][7:0] held_arr_t;

  typedef struct packed {
    logic agree;  // held bytes are a prefix of the pattern
    logic full;   // held bytes are the whole pattern
  } match_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RELEASE,
    ST_REPLACE,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  function automatic logic [7:0] byte_at(logic [WORD_W-1:0] word, int pos);
    if (pos >= WORD_BYTES) begin
      return 8'h00;
    end
    return word[8*pos +: 8];
  endfunction

  function automatic logic [CNT_W-1:0] eff_plen(logic [LEN_W-1:0] len);
    if (len == '0) begin
      return CNT_W'(1);
    end
    if (int'(len) > PATTERN_MAX) begin
      return CNT_W'(PATTERN_MAX);
    end
    return CNT_W'(len);
  endfunction

  function automatic logic [RIDX_W-1:0] eff_rlen(logic [LEN_W-1:0] len);
    if (int'(len) > REPLACE_MAX) begin
      return RIDX_W'(REPLACE_MAX);
    end
    return RIDX_W'(len);
  endfunction

endpackage

// ===== sv/stream_substring_replacer.sv =====
// Top level of the streaming find-and-replace block.
//
// Takes text one byte per input item and rewrites it left to right, replacing
// every non-overlapping occurrence of the configured pattern (1 to 8 bytes) by
// the configured replacement (0 to 8 bytes). Bytes that could still start an
// occurrence are held back; on a mismatch the oldest held byte goes out and the
// rest is compared again. An item with last_byte set flushes everything held
// and its final result carries out_last; if nothing is left to send, a single
// end marker (byte_valid low, out_byte zero) carries it. The block works on one
// item at a time and drops in_ready until that item is done. An item passes
// through an accept step, a pass of the compare unit for each comparison, a
// send step for each byte, a step to end a replacement or a flush, and a
// closing step; the compare unit and the single-byte emit path set this pace,
// and a stalled output adds its wait on top. Each result is parked in a
// pending register until the next result or the close of the item, so the
// last one can be marked, then moves to the output register, which lets the
// next item enter while a result still waits to be taken. Configuration
// writes take effect at once and are meant for idle periods only.
module stream_substring_replacer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ssr_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ssr_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssr_pkg::WORD_W-1:0]       cfg_wdata
);

  // Configuration registers
  logic [ssr_pkg::LEN_W-1:0]  pat_len_r;
  logic [ssr_pkg::WORD_W-1:0] pat_r;
  logic [ssr_pkg::LEN_W-1:0]  rep_len_r;
  logic [ssr_pkg::WORD_W-1:0] rep_r;

  // Sequencer and held bytes
  ssr_pkg::state_t             state_r, state_nxt;
  ssr_pkg::held_arr_t          held_r, held_nxt;
  logic [ssr_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        last_r, last_nxt;
  logic [ssr_pkg::RIDX_W-1:0]  ridx_r, ridx_nxt;

  // Pending result and output register
  logic                        pend_valid_r, pend_valid_nxt;
  logic [7:0]                  pend_byte_r, pend_byte_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ssr_pkg::out_item_t          out_data_r, out_data_nxt;

  logic [ssr_pkg::CNT_W-1:0]   plen_eff;
  logic [ssr_pkg::RIDX_W-1:0]  rlen_eff;
  ssr_pkg::match_t             match;
  logic                        out_free;
  logic                        can_emit;
  logic                        emit;
  logic [7:0]                  emit_byte;

  assign plen_eff = ssr_pkg::eff_plen(pat_len_r);
  assign rlen_eff = ssr_pkg::eff_rlen(rep_len_r);

  ssr_match u_match (
    .held    (held_r),
    .count   (count_r),
    .plen    (plen_eff),
    .pattern (pat_r),
    .result  (match)
  );

  assign out_free  = !out_valid_r || out_ready;
  // A new result may enter when the pending slot is empty or can move on
  assign can_emit  = !pend_valid_r || out_free;

  assign in_ready  = (state_r == ssr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= ssr_pkg::PAT_LEN_RST;
      pat_r     <= ssr_pkg::PAT_RST;
      rep_len_r <= ssr_pkg::REP_LEN_RST;
      rep_r     <= ssr_pkg::REP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::REG_PAT_LEN: pat_len_r <= cfg_wdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_PAT:     pat_r     <= cfg_wdata;
        ssr_pkg::REG_REP_LEN: rep_len_r <= cfg_wdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_REP:     rep_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ssr_pkg::ST_IDLE;
      count_r      <= '0;
      last_r       <= 1'b0;
      ridx_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      last_r       <= last_nxt;
      ridx_r       <= ridx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r      <= held_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    ridx_nxt       = ridx_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    emit           = 1'b0;
    emit_byte      = '0;

    case (state_r)
      ssr_pkg::ST_IDLE: begin
        // Append the new byte behind what is held; held never reaches the max here
        if (in_valid) begin
          held_nxt[count_r[ssr_pkg::IDX_W-1:0]] = in_data.data_byte;
          count_nxt = count_r + 1'b1;
          last_nxt  = in_data.last_byte;
          state_nxt = ssr_pkg::ST_CHECK;
        end
      end

      ssr_pkg::ST_CHECK: begin
        if (match.agree) begin
          if (match.full) begin
            count_nxt = '0;
            ridx_nxt  = '0;
            state_nxt = ssr_pkg::ST_REPLACE;
          end else begin
            state_nxt = last_r ? ssr_pkg::ST_FLUSH : ssr_pkg::ST_FINISH;
          end
        end else begin
          state_nxt = ssr_pkg::ST_RELEASE;
        end
      end

      ssr_pkg::ST_RELEASE: begin
        // Send the oldest held byte, advance the rest and compare again
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = held_r[0];
          for (int i = 0; i < ssr_pkg::PATTERN_MAX - 1; i++) begin
            held_nxt[i] = held_r[i+1];
          end
          count_nxt = count_r - 1'b1;
          state_nxt = ssr_pkg::ST_CHECK;
        end
      end

      ssr_pkg::ST_REPLACE: begin
        if (ridx_r == rlen_eff) begin
          state_nxt = ssr_pkg::ST_FINISH;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_byte = ssr_pkg::byte_at(rep_r, int'(ridx_r));
          ridx_nxt  = ridx_r + 1'b1;
        end
      end

      ssr_pkg::ST_FLUSH: begin
        if (count_r == '0) begin
          state_nxt = ssr_pkg::ST_FINISH;
        end else if (can_emit) begin
          emit      = 1'b1;
          emit_byte = held_r[0];
          for (int i = 0; i < ssr_pkg::PATTERN_MAX - 1; i++) begin
            held_nxt[i] = held_r[i+1];
          end
          count_nxt = count_r - 1'b1;
        end
      end

      ssr_pkg::ST_FINISH: begin
        // Push the pending result; on the last item mark it, or send an end marker
        if (last_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            if (pend_valid_r) begin
              out_data_nxt = '{out_byte: pend_byte_r, byte_valid: 1'b1, out_last: 1'b1};
            end else begin
              out_data_nxt = '{out_byte: 8'h00, byte_valid: 1'b0, out_last: 1'b1};
            end
            pend_valid_nxt = 1'b0;
            state_nxt      = ssr_pkg::ST_IDLE;
          end
        end else if (!pend_valid_r) begin
          state_nxt = ssr_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '{out_byte: pend_byte_r, byte_valid: 1'b1, out_last: 1'b0};
          pend_valid_nxt = 1'b0;
          state_nxt      = ssr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ssr_pkg::ST_IDLE;
      end
    endcase

    // Move the pending byte to the output and park the new one
    if (emit) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{out_byte: pend_byte_r, byte_valid: 1'b1, out_last: 1'b0};
      end
      pend_valid_nxt = 1'b1;
      pend_byte_nxt  = emit_byte;
    end
  end

endmodule

// ===== sv/ssr_match.sv =====
// Compare unit: all held bytes against the pattern prefix in parallel.
module ssr_match (
  input  ssr_pkg::held_arr_t               held,
  input  logic [ssr_pkg::CNT_W-1:0]        count,
  input  logic [ssr_pkg::CNT_W-1:0]        plen,
  input  logic [ssr_pkg::WORD_W-1:0]       pattern,
  output ssr_pkg::match_t                  result
);

  logic mismatch;

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < ssr_pkg::PATTERN_MAX; i++) begin
      if ((i < int'(count)) && (held[i] != ssr_pkg::byte_at(pattern, i))) begin
        mismatch = 1'b1;
      end
    end
    result.agree = (count <= plen) && !mismatch;
    result.full  = result.agree && (count == plen);
  end

endmodule

// ===== sv/ssr_checker.sv =====
// Port-level checks for the streaming substring replacer, bound to the top level.
module ssr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ssr_pkg::out_item_t  out_data
);

  // One item at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted item");

  // An end marker always closes the text
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.out_last)
    else $error("end marker without out_last");

  // An end marker carries a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'h00)
    else $error("end marker with nonzero out_byte");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

endmodule

bind stream_substring_replacer ssr_checker u_ssr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/ssr_checker.sv =====
// Checker for the substring replacer: predicts the rewritten stream and compares results.
module ssr_tb_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ssr_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ssr_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::WORD_W-1:0]    cfg_wdata,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP_CAP    = 16;
  localparam int REPORT_MAX  = 10;

  logic [ssr_pkg::LEN_W-1:0]  pat_len_q;
  logic [ssr_pkg::WORD_W-1:0] pat_q;
  logic [ssr_pkg::LEN_W-1:0]  rep_len_q;
  logic [ssr_pkg::WORD_W-1:0] rep_q;
  logic [7:0]                 held [ssr_pkg::PATTERN_MAX];
  int                         held_n = 0;
  int                         step_n = 0;
  int                         errs = 0;
  ssr_pkg::out_item_t         rewrite_q[$];

  function automatic void emit(logic [7:0] b, logic v);
    if (step_n < STEP_CAP) begin
      rewrite_q.push_back('{out_byte: b, byte_valid: v, out_last: 1'b0});
      step_n++;
    end
  endfunction

  function automatic void flag(string msg);
    errs++;
    if (errs <= REPORT_MAX) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  // Advance the rewrite by one input byte and queue the results it releases.
  function automatic void rewrite_byte(ssr_pkg::in_item_t item);
    int                 plen;
    int                 rlen;
    logic               agree;
    ssr_pkg::out_item_t tail;
    plen = (pat_len_q == '0) ? 1 :
           ((int'(pat_len_q) > ssr_pkg::PATTERN_MAX) ? ssr_pkg::PATTERN_MAX
                                                     : int'(pat_len_q));
    rlen = (int'(rep_len_q) > ssr_pkg::REPLACE_MAX) ? ssr_pkg::REPLACE_MAX
                                                    : int'(rep_len_q);
    step_n = 0;
    if (held_n < ssr_pkg::PATTERN_MAX) begin
      held[held_n] = item.data_byte;
      held_n++;
    end
    while (held_n > 0) begin
      agree = (held_n <= plen);
      for (int i = 0; agree && i < held_n; i++) begin
        if (held[i] != pat_q[8*i +: 8]) agree = 1'b0;
      end
      if (agree) begin
        if (held_n == plen) begin
          for (int i = 0; i < rlen; i++) emit(rep_q[8*i +: 8], 1'b1);
          held_n = 0;
        end
        break;
      end
      // release the oldest byte and rescan the rest
      emit(held[0], 1'b1);
      for (int i = 1; i < held_n; i++) held[i-1] = held[i];
      held_n--;
    end
    if (item.last_byte) begin
      for (int i = 0; i < held_n; i++) emit(held[i], 1'b1);
      held_n = 0;
      if (step_n == 0) emit(8'h00, 1'b0);
      tail = rewrite_q.pop_back();
      tail.out_last = 1'b1;
      rewrite_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    ssr_pkg::out_item_t want;
    if (!rst_n) begin
      pat_len_q = ssr_pkg::PAT_LEN_RST;
      pat_q     = ssr_pkg::PAT_RST;
      rep_len_q = ssr_pkg::REP_LEN_RST;
      rep_q     = ssr_pkg::REP_RST;
      held_n    = 0;
      rewrite_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ssr_pkg::REG_PAT_LEN: pat_len_q = cfg_wdata[ssr_pkg::LEN_W-1:0];
          ssr_pkg::REG_PAT:     pat_q     = cfg_wdata;
          ssr_pkg::REG_REP_LEN: rep_len_q = cfg_wdata[ssr_pkg::LEN_W-1:0];
          ssr_pkg::REG_REP:     rep_q     = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (rewrite_q.size() == 0) begin
          flag($sformatf("unexpected result: byte %02h valid %0b last %0b",
                         out_data.out_byte, out_data.byte_valid, out_data.out_last));
        end else begin
          want = rewrite_q.pop_front();
          if (want !== out_data) begin
            flag($sformatf({"result mismatch: expected byte %02h valid %0b last %0b,",
                            " got byte %02h valid %0b last %0b"},
                           want.out_byte, want.byte_valid, want.out_last,
                           out_data.out_byte, out_data.byte_valid, out_data.out_last));
          end
        end
      end
      if (in_valid && in_ready) rewrite_byte(in_data);
    end
    pending    <= rewrite_q.size();
    mismatches <= errs;
  end

endmodule

// ===== sim/tb_stream_substring_replacer.sv =====
// Testbench top for the substring replacer: stimulus, receiver stalls and verdict.
module tb_stream_substring_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 370;
  localparam int SETTLE_CYCLES = 40;   // comfortably above the worst item latency
  localparam int CYCLE_LIMIT  = 600000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  ssr_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  ssr_pkg::out_item_t            out_data;
  logic                          cfg_we;
  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ssr_pkg::WORD_W-1:0]    cfg_wdata;
  int                            mismatches;
  int                            pending;

  // Sender pacing and the view of the current pattern used to build text
  int                            burst_left = 4;
  int                            gap_max = 0;
  int                            pat_eff = 3;
  logic [ssr_pkg::WORD_W-1:0]    pat_word = ssr_pkg::PAT_RST;
  logic [7:0]                    text_q[$];
  int                            random_sent = 0;
  int                            cycle_count = 0;
  int                            rx_mode = 0;
  int                            rx_left = 0;

  stream_substring_replacer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssr_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: switch between always ready, coin-flip ready and long stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Offer one item and hold it until accepted, then maybe open an idle gap.
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Drop valid and hold off until every expected result has been taken and the
  // block has had time to finish any item that releases nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; length writes carry junk above bit 3.
  task automatic load_config(logic [ssr_pkg::LEN_W-1:0] plen,
                             logic [ssr_pkg::WORD_W-1:0] pat,
                             logic [ssr_pkg::LEN_W-1:0] rlen,
                             logic [ssr_pkg::WORD_W-1:0] rep);
    logic [ssr_pkg::WORD_W-1:0] wd;
    wd = {$urandom(), $urandom()};
    wd[ssr_pkg::LEN_W-1:0] = plen;
    cfg_we    <= 1'b1;
    cfg_index <= ssr_pkg::REG_PAT_LEN;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_index <= ssr_pkg::REG_PAT;
    cfg_wdata <= pat;
    @(posedge clk);
    wd = {$urandom(), $urandom()};
    wd[ssr_pkg::LEN_W-1:0] = rlen;
    cfg_index <= ssr_pkg::REG_REP_LEN;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_index <= ssr_pkg::REG_REP;
    cfg_wdata <= rep;
    @(posedge clk);
    cfg_we <= 1'b0;
    pat_word = pat;
    pat_eff  = (plen == '0) ? 1 :
               ((int'(plen) > ssr_pkg::PATTERN_MAX) ? ssr_pkg::PATTERN_MAX : int'(plen));
  endtask

  // Refill the text with a whole occurrence, a partial one, a pattern byte,
  // a near-alphabet byte or plain noise.
  task automatic grow_text();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      for (int i = 0; i < pat_eff; i++) text_q.push_back(pat_word[8*i +: 8]);
    end else if (r < 60 && pat_eff > 1) begin
      n = $urandom_range(1, pat_eff - 1);
      for (int i = 0; i < n; i++) text_q.push_back(pat_word[8*i +: 8]);
    end else if (r < 80) begin
      n = $urandom_range(0, pat_eff - 1);
      text_q.push_back(pat_word[8*n +: 8]);
    end else if (r < 90) begin
      text_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Random pattern word: each byte mostly from a three-letter alphabet to force rescans.
  function automatic logic [ssr_pkg::WORD_W-1:0] alphabet_word();
    logic [ssr_pkg::WORD_W-1:0] w;
    for (int i = 0; i < ssr_pkg::WORD_BYTES; i++) begin
      w[8*i +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'h61 + 8'($urandom_range(0, 2));
    end
    return w;
  endfunction

  initial begin
    int                         phase;
    int                         count;
    logic                       last;
    logic [ssr_pkg::LEN_W-1:0]  plen;
    logic [ssr_pkg::LEN_W-1:0]  rlen;
    logic [ssr_pkg::WORD_W-1:0] pat;
    logic [ssr_pkg::WORD_W-1:0] rep;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = ssr_pkg::REG_PAT_LEN;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern: partial match broken by a zero byte, a doubled first
    // letter that needs a rescan, a full match, an all-ones byte, and a
    // partial match flushed by the last byte.
    gap_max = 3;
    send_byte("C", 1'b0);
    send_byte("a", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte("C", 1'b0);
    send_byte("C", 1'b0);
    send_byte("a", 1'b0);
    send_byte("o", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte("C", 1'b0);
    send_byte("a", 1'b1);
    settle();

    // Empty replacement completed by the last byte: end marker only. Then a
    // one-byte text that passes straight through.
    load_config(4'd2, 64'h6261, 4'd0, {$urandom(), $urandom()});
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    send_byte("x", 1'b1);
    settle();

    // Zero pattern length acts as one byte; replacement length saturates.
    load_config(4'd0, 64'hFF, 4'd15, {$urandom(), $urandom()});
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // Pattern length saturates at eight; a late mismatch releases one byte.
    load_config(4'd12, 64'h6261616161616161, 4'd8, {$urandom(), $urandom()});
    for (int i = 0; i < 8; i++) send_byte("a", 1'b0);
    send_byte("b", 1'b1);
    settle();

    // Random phases: fresh settings each time, some phases stop mid-text so
    // the next settings meet held bytes.
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          plen = 4'd8;  pat = alphabet_word();  rlen = 4'd8;  rep = {$urandom(), $urandom()};
        end
        1: begin
          plen = 4'd1;  pat = '0;  rlen = 4'd0;  rep = '1;
        end
        2: begin
          plen = 4'd15; pat = '1;  rlen = 4'd15; rep = '0;
        end
        default: begin
          plen = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 4));
          pat  = alphabet_word();
          rlen = 4'($urandom_range(0, 15));
          rep  = {$urandom(), $urandom()};
        end
      endcase
      load_config(plen, pat, rlen, rep);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      text_q.delete();
      count = $urandom_range(30, 45);
      for (int i = 0; i < count; i++) begin
        if (text_q.size() == 0) grow_text();
        last = ($urandom_range(0, 14) == 0);
        if (i == count - 1) begin
          // close the text on most phases; always close it at the very end
          last = ($urandom_range(0, 2) != 0) || (random_sent + 1 >= RANDOM_ITEMS);
        end
        send_byte(text_q.pop_front(), last);
        random_sent++;
      end
      settle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ssr_pkg.sv
sv/ssr_match.sv
sv/stream_substring_replacer.sv
sv/ssr_checker.sv
sim/ssr_checker.sv
sim/tb_stream_substring_replacer.sv
